FILE: rtl/slab_pkg.sv
// Package for the sRGB linear-light alpha blender.
// Holds the ROM table type and the elaboration-time builders for the decode and
// re-encode tables. No dependencies.
`default_nettype none
package slab_pkg;

	localparam int unsigned CODES = 256;
	localparam int unsigned CH_NUM = 3;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	typedef logic [63:0] rom_t [CODES];

	function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
		return (a * b) >> 30;
	endfunction

	function automatic logic [63:0] q30_pow5(logic [63:0] r);
		logic [63:0] r2;
		logic [63:0] r4;
		r2 = q30_mul(r, r);
		r4 = q30_mul(r2, r2);
		return q30_mul(r4, r);
	endfunction

	// largest Q30 value whose truncated fifth power stays at or below x
	function automatic logic [63:0] q30_root5(logic [63:0] x);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		lo = 64'd0;
		hi = Q30_ONE;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			if (q30_pow5(mid) <= x)
				lo = mid;
			else
				hi = mid - 64'd1;
		end
		return lo;
	endfunction

	// x^2.4 as x^2 * (x^(1/5))^2, x already in Q30
	function automatic logic [63:0] q30_pow24(logic [63:0] x);
		logic [63:0] r;
		r = q30_root5(x);
		return q30_mul(q30_mul(x, x), q30_mul(r, r));
	endfunction

	function automatic rom_t build_lin(int unsigned frac);
		rom_t rom;
		logic [63:0] n;
		logic [63:0] x;
		logic [63:0] y;
		int unsigned sh;
		sh = 30 - frac;
		for (int unsigned c = 0; c < CODES; c++) begin
			if (c <= 10) begin
				n = (64'(c) * 64'd10) << frac;
				rom[c] = (n + 64'd16473) / 64'd32946;
			end else begin
				x = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
				y = q30_pow24(x);
				rom[c] = (y + (64'd1 << (sh - 1))) >> sh;
			end
		end
		return rom;
	endfunction

	function automatic rom_t build_thr(int unsigned frac);
		rom_t rom;
		logic [63:0] n;
		logic [63:0] x;
		logic [63:0] y;
		int unsigned sh;
		sh = 30 - frac;
		rom[0] = 64'd0;
		for (int unsigned k = 1; k < CODES; k++) begin
			if (k <= 10) begin
				n = ((64'd2 * 64'(k) - 64'd1) * 64'd10) << frac;
				rom[k] = (n + 64'd65891) / 64'd65892;
			end else begin
				x = (((64'd2 * 64'(k) - 64'd1) * 64'd1000 + 64'd28050) << 30) / 64'd538050;
				y = q30_pow24(x);
				rom[k] = (y + (64'd1 << sh) - 64'd1) >> sh;
			end
		end
		return rom;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/srgb_linear_alpha_blend_core.sv
// Gamma-correct alpha blender: seven stages, one pixel per clock unless stalled.
// Depends on slab_pkg for the decode and threshold ROM builders.
`default_nettype none
// Blends a foreground sRGB pixel over a background one in linear light. Each
// channel is decoded through a 256-entry ROM, mixed by opacity/255 with rounding,
// and re-encoded by counting the thresholds that the mixed level reaches. The
// core takes one pixel per clock unless stalled and passes it through
// ROM read, two multiplies, sum, reciprocal multiply for the divide by 255,
// correction, threshold compare, and count. Each stage holds only while the one
// after it is full and stalled; a stalled output never blocks upstream bubbles.
module srgb_linear_alpha_blend_core #(
	parameter int unsigned LINEAR_FRAC_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] fore_red,
	input  wire logic [7:0] fore_green,
	input  wire logic [7:0] fore_blue,
	input  wire logic [7:0] opacity,
	input  wire logic [7:0] back_red,
	input  wire logic [7:0] back_green,
	input  wire logic [7:0] back_blue,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      mixed_red,
	output logic [7:0]      mixed_green,
	output logic [7:0]      mixed_blue
);

	localparam int unsigned W  = LINEAR_FRAC_BITS + 1;
	localparam int unsigned PW = W + 8;
	localparam int unsigned XW = LINEAR_FRAC_BITS + 8;
	localparam int unsigned K  = XW + 8;
	localparam int unsigned RW = K - 7;
	localparam logic [K:0]  POW_K = {1'b1, {K{1'b0}}};
	localparam logic [K:0]  RECIP_WIDE = POW_K / 255;
	localparam logic [RW-1:0] RECIP = RECIP_WIDE[RW-1:0];
	localparam slab_pkg::rom_t LIN_ROM = slab_pkg::build_lin(LINEAR_FRAC_BITS);
	localparam slab_pkg::rom_t THR_ROM = slab_pkg::build_thr(LINEAR_FRAC_BITS);
	localparam int unsigned NCH = slab_pkg::CH_NUM;

	logic [7:0] fore [NCH];
	logic [7:0] back [NCH];
	assign fore[0] = fore_red;
	assign fore[1] = fore_green;
	assign fore[2] = fore_blue;
	assign back[0] = back_red;
	assign back[1] = back_green;
	assign back[2] = back_blue;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	// a stage moves when it is empty or its successor moves
	assign en7 = !v_s7 || out_ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	logic [7:0]       a_s1;
	logic [W-1:0]     lf_s1 [NCH];
	logic [W-1:0]     lb_s1 [NCH];
	logic [PW-1:0]    pf_s2 [NCH];
	logic [PW-1:0]    pb_s2 [NCH];
	logic [XW-1:0]    x_s3  [NCH];
	logic [XW-1:0]    x_s4  [NCH];
	logic [XW+RW-1:0] pr_s4 [NCH];
	logic [W-1:0]     t_s5  [NCH];
	logic [255:1]     ge_s6 [NCH];
	logic [7:0]       code_s7 [NCH];

	logic [W-1:0]  q_est [NCH];
	logic [XW-1:0] rem   [NCH];
	logic [7:0]    cnt   [NCH];

	always_ff @(posedge clk) begin
		if (en1) a_s1 <= opacity;
	end

	for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
		always_comb begin
			q_est[ch] = pr_s4[ch][XW+RW-1:K];
			rem[ch] = x_s4[ch] - ((XW'(q_est[ch]) << 8) - XW'(q_est[ch]));
			// compares form a thermometer code: find its length bit by bit
			cnt[ch] = 8'd0;
			for (int b = 7; b >= 0; b--)
				if (ge_s6[ch][cnt[ch] | (8'd1 << b)])
					cnt[ch] = cnt[ch] | (8'd1 << b);
		end

		always_ff @(posedge clk) begin
			if (en1) begin
				lf_s1[ch] <= LIN_ROM[fore[ch]][W-1:0];
				lb_s1[ch] <= LIN_ROM[back[ch]][W-1:0];
			end
			if (en2) begin
				pf_s2[ch] <= PW'(a_s1) * PW'(lf_s1[ch]);
				pb_s2[ch] <= PW'(8'd255 - a_s1) * PW'(lb_s1[ch]);
			end
			if (en3)
				x_s3[ch] <= XW'(pf_s2[ch] + pb_s2[ch] + PW'(127));
			if (en4) begin
				x_s4[ch] <= x_s3[ch];
				pr_s4[ch] <= (XW+RW)'(x_s3[ch]) * (XW+RW)'(RECIP);
			end
			// estimate is at most one short of the true quotient
			if (en5)
				t_s5[ch] <= (rem[ch] >= XW'(255)) ? q_est[ch] + W'(1) : q_est[ch];
			if (en6)
				for (int k = 1; k < 256; k++)
					ge_s6[ch][k] <= t_s5[ch] >= THR_ROM[k][W-1:0];
			if (en7)
				code_s7[ch] <= cnt[ch];
		end
	end

	assign out_valid   = v_s7;
	assign mixed_red   = code_s7[0];
	assign mixed_green = code_s7[1];
	assign mixed_blue  = code_s7[2];

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> t_s5[0] <= (W'(1) << LINEAR_FRAC_BITS))
		else $error("blended level above full scale");

	a_div_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (rem[1] < XW'(510)))
		else $error("reciprocal estimate off by more than one");

	a_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (((ge_s6[2] >> 1) & ~ge_s6[2]) == 255'd0))
		else $error("threshold compares not a thermometer code");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !out_ready |=> $stable(code_s7[0]) && v_s7)
		else $error("stalled result changed");

endmodule
`default_nettype wire
